### rtl/core/tmat_pkg.sv
`default_nettype none
package tmat_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TOT_W = 16 + CNT_W;
  localparam logic [6:0] MIN_COUNT = 7'd3;
  localparam logic [15:0] CODE_MAX = 16'hFFFF;
  localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [0:0] REG_TABLE_SIZE = 1'b1;
  localparam logic FUNC_ENTRY = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MDIV, ST_RDLO, ST_RDHI, ST_CHKLO, ST_CHKHI,
    ST_RDMID, ST_CMPMID, ST_RDLOW2, ST_RDHIGH2, ST_BRK, ST_MUL, ST_TDIV, ST_FIN, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### rtl/core/trimmed_mean_adc_to_temperature_core.sv
// channel | dir | handshake            | payload
// s_axis  | in  | tvalid/tready        | tdata: entry_index, entry_code, entry_temp, sample;
//         |     |                      | tuser: func
// m_axis  | out | tvalid/tready        | tdata: mean_code, temperature
// cfg     | in  | cfg_we (no wait)     | cfg_index, cfg_data
// table writes and non-final samples are accepted while idle. the final sample of a
// conversion runs a serial mean division, end checks against the first and last
// table entries, a binary search over the table memory (a probe is ST_RDMID then
// ST_CMPMID), three bracket states, one multiply, a serial division and a
// saturation step; it stops early at an end entry or an exact code match.
// rst is synchronous; the table memory is not cleared. input is held off while
// a conversion runs or a result waits to be taken.
`default_nettype none
module trimmed_mean_adc_to_temperature_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] entry_index, [20:5] entry_code, [36:21] entry_temp, [52:37] sample
  input  wire logic [55:0] s_axis_tdata,
  // [0] func
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] mean_code, [31:16] temperature
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);
  localparam int IW = tmat_pkg::IDX_W;
  localparam int TW = tmat_pkg::TOT_W;

  logic [6:0] sample_count;
  logic [5:0] table_size;
  logic [31:0] mem [tmat_pkg::TABLE_DEPTH];
  logic [31:0] rd;
  logic [IW-1:0] raddr;
  logic        wen;

  tmat_pkg::state_t state, state_next;
  logic [TW-1:0] total;
  logic [15:0] largest, smallest, mean;
  logic [tmat_pkg::CNT_W-1:0] taken;
  logic [6:0] need;
  logic [IW:0] n;
  logic signed [IW+1:0] low, high, mid;
  logic signed [IW+1:0] mid_dn, mid_up, last_idx;
  logic [31:0] lo_e, hi_e;
  logic signed [15:0] result;
  // shared serial divider
  logic [47:0] rem, quo, dvs;
  logic        neg;
  logic [5:0]  dcnt;
  logic signed [16:0] dtemp, dcode;
  logic signed [33:0] prod;

  logic s_acc, is_last;
  logic [15:0] s;
  assign s = s_axis_tdata[52:37];
  assign s_axis_tready = (state == tmat_pkg::ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    need = sample_count;
    if (need > 7'(tmat_pkg::MAX_SAMPLES)) need = 7'(tmat_pkg::MAX_SAMPLES);
    if (need < tmat_pkg::MIN_COUNT) need = tmat_pkg::MIN_COUNT;
    n = (table_size == 6'd0) ? (IW+1)'(1) : (table_size > 6'(tmat_pkg::TABLE_DEPTH)) ?
        (IW+1)'(tmat_pkg::TABLE_DEPTH) : table_size[IW:0];
  end
  assign is_last = (7'(taken) + 7'd1) >= need;

  assign mid_dn = mid - (IW+2)'(1);
  assign mid_up = mid + (IW+2)'(1);
  assign last_idx = (IW+2)'(n) - (IW+2)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= tmat_pkg::MIN_COUNT;
      table_size <= 6'd1;
    end else if (cfg_we) begin
      if (cfg_index == tmat_pkg::REG_SAMPLE_COUNT) sample_count <= cfg_data;
      else table_size <= cfg_data[5:0];
    end
  end

  assign wen = s_acc && s_axis_tuser == tmat_pkg::FUNC_ENTRY;
  always_ff @(posedge clk) begin
    if (wen) mem[s_axis_tdata[IW-1:0]] <= s_axis_tdata[36:5];
    rd <= mem[raddr];
  end

  // first entry is read in ST_RDLO, last entry in ST_CHKLO
  always_comb begin
    unique case (state)
      tmat_pkg::ST_CHKLO: raddr = IW'(n - 1);
      tmat_pkg::ST_RDMID: raddr = mid[IW-1:0];
      tmat_pkg::ST_RDLOW2: raddr = low[IW-1:0];
      tmat_pkg::ST_RDHIGH2: raddr = high[IW-1:0];
      default: raddr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmat_pkg::ST_IDLE:
        if (s_acc && s_axis_tuser != tmat_pkg::FUNC_ENTRY && is_last)
          state_next = tmat_pkg::ST_MDIV;
      tmat_pkg::ST_MDIV: if (dcnt == 6'd0) state_next = tmat_pkg::ST_RDLO;
      tmat_pkg::ST_RDLO: state_next = tmat_pkg::ST_RDHI;
      tmat_pkg::ST_RDHI: state_next = tmat_pkg::ST_CHKLO;
      tmat_pkg::ST_CHKLO:
        state_next = (rd[15:0] >= mean) ? tmat_pkg::ST_OUT : tmat_pkg::ST_CHKHI;
      tmat_pkg::ST_CHKHI:
        state_next = (rd[15:0] <= mean) ? tmat_pkg::ST_OUT : tmat_pkg::ST_RDMID;
      tmat_pkg::ST_RDMID: state_next = tmat_pkg::ST_CMPMID;
      tmat_pkg::ST_CMPMID:
        if (rd[15:0] == mean) state_next = tmat_pkg::ST_OUT;
        else if ((rd[15:0] > mean && low > mid_dn) || (rd[15:0] < mean && mid_up > high))
          state_next = tmat_pkg::ST_RDLOW2;
        else state_next = tmat_pkg::ST_RDMID;
      tmat_pkg::ST_RDLOW2: state_next = tmat_pkg::ST_RDHIGH2;
      tmat_pkg::ST_RDHIGH2: state_next = tmat_pkg::ST_BRK;
      tmat_pkg::ST_BRK:
        state_next = (lo_e[15:0] == rd[15:0]) ? tmat_pkg::ST_OUT : tmat_pkg::ST_MUL;
      tmat_pkg::ST_MUL: state_next = tmat_pkg::ST_TDIV;
      tmat_pkg::ST_TDIV: if (dcnt == 6'd0) state_next = tmat_pkg::ST_FIN;
      tmat_pkg::ST_FIN: state_next = tmat_pkg::ST_OUT;
      tmat_pkg::ST_OUT: if (m_axis_tready) state_next = tmat_pkg::ST_IDLE;
      default: state_next = tmat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    m_axis_tvalid = (state == tmat_pkg::ST_OUT);
    m_axis_tdata = {result, mean};
  end

  logic [48:0] trial;
  assign trial = {1'b0, rem[46:0], quo[47]} - {1'b0, dvs};
  logic signed [34:0] tsum;
  assign tsum = 35'(signed'(hi_e[31:16])) +
                (neg ? -35'(signed'({1'b0, quo[33:0]})) : 35'(signed'({1'b0, quo[33:0]})));

  // code difference may be negative when the table is not ascending
  assign dtemp = 17'(signed'(lo_e[31:16])) - 17'(signed'(hi_e[31:16]));
  assign dcode = signed'({1'b0, mean}) - signed'({1'b0, hi_e[15:0]});
  assign prod = dtemp * dcode;

  always_ff @(posedge clk) begin
    if (rst) state <= tmat_pkg::ST_IDLE;
    else state <= state_next;
    if (rst) begin
      total <= '0; largest <= '0; smallest <= tmat_pkg::CODE_MAX; taken <= '0;
    end else if (s_acc && s_axis_tuser != tmat_pkg::FUNC_ENTRY) begin
      if (taken == '0) begin
        largest <= s; smallest <= s;
      end else if (s > largest) largest <= s;
      else if (s < smallest) smallest <= s;
      if (is_last) begin
        total <= '0; taken <= '0;
        // mean division setup: dividend total+s-max-min, divisor taken-1
        rem <= '0;
        dvs <= 48'(taken) - 48'd1;
        dcnt <= 6'(TW - 1);
        if (taken == '0) quo <= {TW'(0), (48-TW)'(0)};
        else if (s > largest) quo <= {TW'(total - TW'(smallest)), (48-TW)'(0)};
        else if (s < smallest) quo <= {TW'(total - TW'(largest)), (48-TW)'(0)};
        else quo <= {TW'(total + TW'(s) - TW'(largest) - TW'(smallest)), (48-TW)'(0)};
      end else begin
        total <= total + TW'(s);
        taken <= taken + 1'b1;
      end
    end
    unique case (state)
      tmat_pkg::ST_MDIV, tmat_pkg::ST_TDIV: begin
        if (!trial[48]) begin
          rem <= trial[47:0]; quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], quo[47]}; quo <= {quo[46:0], 1'b0};
        end
        if (dcnt != 6'd0) dcnt <= dcnt - 1'b1;
        if (state == tmat_pkg::ST_MDIV && dcnt == 6'd0)
          mean <= !trial[48] ? {quo[14:0], 1'b1} : {quo[14:0], 1'b0};
      end
      tmat_pkg::ST_CHKLO: begin
        result <= signed'(rd[31:16]);
        low <= '0; high <= last_idx; mid <= last_idx >>> 1;
      end
      tmat_pkg::ST_CHKHI: result <= signed'(rd[31:16]);
      tmat_pkg::ST_CMPMID: begin
        result <= signed'(rd[31:16]);
        if (rd[15:0] > mean) begin
          high <= mid_dn[IW+1] ? '0 : mid_dn;
          mid <= (low + mid_dn) >>> 1;
        end else begin
          low <= (mid_up > last_idx) ? last_idx : mid_up;
          mid <= (mid_up + high) >>> 1;
        end
      end
      tmat_pkg::ST_RDHIGH2: lo_e <= rd;
      tmat_pkg::ST_BRK: begin
        hi_e <= rd;
        result <= signed'(rd[31:16]);
      end
      tmat_pkg::ST_MUL: begin
        neg <= prod[33] ^ (lo_e[15:0] < hi_e[15:0]);
        quo <= {(prod[33] ? 34'(-prod) : 34'(prod)), 14'd0};
        rem <= '0;
        dvs <= 48'((lo_e[15:0] < hi_e[15:0]) ? hi_e[15:0] - lo_e[15:0] : lo_e[15:0] - hi_e[15:0]);
        dcnt <= 6'd33;
      end
      tmat_pkg::ST_FIN:
        result <= (tsum > 35'sd32767) ? 16'sh7FFF :
                  (tsum < -35'sd32768) ? -16'sh8000 : tsum[15:0];
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    7'(taken) < 7'(tmat_pkg::MAX_SAMPLES))
    else $error("sample count overrun");
endmodule
`default_nettype wire
